### sv/hs_pkg.sv
// shared types and constants for the heap sorter block
// no dependencies; imported by every module of the block
package hs_pkg;

   // store capacity and counter width (count must hold the capacity itself)
   localparam int MAX_ELEMS = 64;
   localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
   localparam int DATA_W    = 32;

   // input request payload
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } req_type;

   // result payload
   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     last_res;
      logic                     overflow;
   } rsp_type;

   // top level control states
   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   // operation broadcast to every cell of the chain
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_SHIFT_LEFT,
      OP_SHIFT_RIGHT
   } cell_op_type;

   // control group sent to all cells
   typedef struct packed {
      cell_op_type              op;
      logic signed [DATA_W-1:0] x;
   } cell_ctl_type;

   // what one cell shows its neighbors
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     valid;
      logic                     lt;
   } cell_link_type;

endpackage

### sv/hs_cell.sv
// one cell of the sorting chain: holds a single value and its valid bit
// depends on hs_pkg for the control and neighbor link types
module hs_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  hs_pkg::cell_ctl_type  ctl,
   input  hs_pkg::cell_link_type left_link,
   input  hs_pkg::cell_link_type right_link,
   output hs_pkg::cell_link_type link
);
   import hs_pkg::*;

   logic signed [DATA_W-1:0] value_ff, value_in;
   logic                     valid_ff, valid_in;
   logic                     lt;

   // new value belongs at or below this cell (empty cells count as +inf)
   assign lt = !valid_ff || (ctl.x < value_ff);

   // next value for insert and the two shift directions
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      case (ctl.op)
         OP_INSERT: begin
            if (lt) begin
               if (left_link.lt) begin
                  value_in = left_link.value;
                  valid_in = left_link.valid;
               end else begin
                  value_in = ctl.x;
                  valid_in = 1'b1;
               end
            end
         end
         OP_SHIFT_LEFT: begin
            value_in = right_link.value;
            valid_in = right_link.valid;
         end
         OP_SHIFT_RIGHT: begin
            value_in = left_link.value;
            valid_in = left_link.valid;
         end
         default: begin
            value_in = value_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign link.value = value_ff;
   assign link.valid = valid_ff;
   assign link.lt    = lt;

endmodule

### sv/heap_sorter.sv
// heap sorter top level: load control, output register and the cell chain
// depends on hs_pkg and hs_cell
//
// usage:
//   req channel (valid/ready) takes one signed 32-bit value per cycle; each
//   value is inserted into a chain of 64 cells kept in ascending order, so
//   loading runs at one request per cycle. A request with last set closes
//   the set; values past 64 are dropped and flag overflow on every result.
//   csr_write_en/csr_write_data set the order bit (1 = descending); the bit
//   is sampled when the last request is taken.
//   rsp channel (valid/ready) returns the n stored values in order, last_res
//   on the final one. Ascending: the first result follows the last request via
//   the state and output registers, then one result per cycle unless rsp_ready
//   stalls. Descending: the chain first shifts its 64-n empty top cells out.
//   req_ready is low from the last request until the final result is loaded
//   into the output register. A stalled rsp_ready freezes the chain; the
//   output register lets the next set start loading while the final result
//   still waits. Reset (synchronous, active high) empties the chain, clears
//   count and overflow, and sets ascending order.
module heap_sorter (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  hs_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output hs_pkg::rsp_type rsp_data,
   input  logic            csr_write_en,
   input  logic            csr_write_data
);
   import hs_pkg::*;

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ELEMS);
   localparam logic [CNT_W-1:0] ONE_COUNT = CNT_W'(1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             desc_ff;
   logic             sort_desc_ff, sort_desc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_load;
   logic             out_free;
   cell_ctl_type     ctl;
   cell_link_type    links [MAX_ELEMS];
   cell_link_type    head;

   // cell chain
   for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
      cell_link_type left_link, right_link;
      if (i == 0) begin : g_lo
         assign left_link = '0;
      end else begin : g_lo_n
         assign left_link = links[i-1];
      end
      if (i == MAX_ELEMS - 1) begin : g_hi
         assign right_link = '0;
      end else begin : g_hi_n
         assign right_link = links[i+1];
      end
      hs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .left_link  (left_link),
         .right_link (right_link),
         .link       (links[i])
      );
   end

   // output end of the chain depends on the order
   assign head     = sort_desc_ff ? links[MAX_ELEMS-1] : links[0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state and chain control
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      sort_desc_in = sort_desc_ff;
      req_ready    = 1'b0;
      rsp_load     = 1'b0;
      rsp_in       = rsp_ff;
      ctl.op       = OP_HOLD;
      ctl.x        = req_data.value;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff == MAX_COUNT) begin
                  ovf_in = 1'b1;
               end else begin
                  ctl.op   = OP_INSERT;
                  count_in = count_ff + ONE_COUNT;
               end
               if (req_data.last) begin
                  state_in     = ST_DRAIN;
                  sort_desc_in = desc_ff;
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               ctl.op = sort_desc_ff ? OP_SHIFT_RIGHT : OP_SHIFT_LEFT;
               if (head.valid) begin
                  rsp_load            = 1'b1;
                  rsp_in.sorted_value = head.value;
                  rsp_in.last_res     = (count_ff == ONE_COUNT);
                  rsp_in.overflow     = ovf_ff;
                  count_in            = count_ff - ONE_COUNT;
                  if (count_ff == ONE_COUNT) begin
                     state_in = ST_LOAD;
                     ovf_in   = 1'b0;
                  end
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // output valid
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         sort_desc_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         desc_ff      <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         sort_desc_ff <= sort_desc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            desc_ff <= csr_write_data;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### sv/hs_checker.sv
// port level checks for the heap sorter, bound to the top level
// depends on hs_pkg and heap_sorter
module hs_checker (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input hs_pkg::req_type req_data,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input hs_pkg::rsp_type rsp_data
);
   import hs_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // input stalls right after the request that closes a set
   a_last_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last |=> !req_ready)
      else $error("request taken during sort walk");

   // while a set is still being returned no request is taken
   a_walk_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_res |-> !req_ready)
      else $error("input open before set finished");

   // overflow flag stays the same within a set
   a_ovf_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_res ##1 rsp_valid
      |-> rsp_data.overflow == $past(rsp_data.overflow))
      else $error("overflow flag changed within a set");

endmodule

bind heap_sorter hs_checker u_hs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### tb/sv/tb.sv
// testbench for heap_sorter: random request bursts, stalled results, both sort orders
// depends on hs_pkg and the heap_sorter rtl; checks every result against a local sort
module tb;
   import hs_pkg::*;

   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int IDLE_GAP       = 80;
   localparam int TAIL_CYCLES    = 150;
   localparam int PHASE_REQS     = 10;

   // receiver stall behaviors
   typedef enum logic [1:0] {
      RX_FREE,
      RX_HALF,
      RX_SPARSE,
      RX_BUSY
   } rx_mode_type;

   logic    clock;
   logic    reset          = 1'b1;
   logic    req_valid      = 1'b0;
   logic    req_ready;
   req_type req_data       = '0;
   logic    rsp_valid;
   logic    rsp_ready      = 1'b0;
   rsp_type rsp_data;
   logic    csr_write_en   = 1'b0;
   logic    csr_write_data = 1'b0;

   heap_sorter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // requests waiting to be sent and sorted values waiting to come back
   req_type pending_reqs[$];
   rsp_type sorted_results[$];

   // local copy of the block state
   logic signed [DATA_W-1:0] stored [MAX_ELEMS];
   int unsigned stored_count  = 0;
   bit          dropped       = 1'b0;
   bit          order_desc    = 1'b0;

   int unsigned queued_reqs     = 0;
   int unsigned accepted_reqs   = 0;
   int unsigned checked_results = 0;
   int unsigned sets_sorted     = 0;
   int unsigned desc_sets       = 0;
   int unsigned overflow_sets   = 0;
   int unsigned fail_count      = 0;
   int unsigned stall_cycles    = 0;
   bit          req_taken       = 1'b0;
   int          hold_asked      = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // true when a belongs ahead of b in the output order
   function automatic bit goes_first(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b);
      return order_desc ? (a > b) : (a < b);
   endfunction

   // store one request; a last request sorts the set and queues its results
   task automatic load_value(input req_type r);
      logic signed [DATA_W-1:0] v;
      logic signed [DATA_W-1:0] key;
      rsp_type                  e;
      int                       j;
      int                       n;
      v = r.value;
      if (stored_count < MAX_ELEMS) begin
         stored[stored_count] = v;
         stored_count++;
      end else begin
         dropped = 1'b1;
      end
      if (r.last) begin
         n = stored_count;
         for (int i = 1; i < n; i++) begin
            key = stored[i];
            j = i;
            while (j > 0 && goes_first(key, stored[j-1])) begin
               stored[j] = stored[j-1];
               j--;
            end
            stored[j] = key;
         end
         for (int k = 0; k < n; k++) begin
            e.sorted_value = stored[k];
            e.last_res     = (k == n - 1);
            e.overflow     = dropped;
            sorted_results.push_back(e);
         end
         sets_sorted++;
         if (order_desc) desc_sets++;
         if (dropped) overflow_sets++;
         stored_count = 0;
         dropped      = 1'b0;
      end
   endtask

   // accept side: predict on requests, check results, watch for a hang
   always @(posedge clock) begin : monitor
      rsp_type want;
      req_taken = !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_taken) begin
            accepted_reqs++;
            load_value(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            checked_results++;
            if (sorted_results.size() == 0) begin
               $display("%0t: unexpected result value %0d last %0b overflow %0b", $time,
                        $signed(rsp_data.sorted_value), rsp_data.last_res, rsp_data.overflow);
               fail_count++;
            end else begin
               want = sorted_results.pop_front();
               if (rsp_data.sorted_value !== want.sorted_value) begin
                  $display("%0t: sorted_value expected %0d got %0d", $time,
                           $signed(want.sorted_value), $signed(rsp_data.sorted_value));
                  fail_count++;
               end
               if (rsp_data.last_res !== want.last_res) begin
                  $display("%0t: last_res expected %0b got %0b", $time,
                           want.last_res, rsp_data.last_res);
                  fail_count++;
               end
               if (rsp_data.overflow !== want.overflow) begin
                  $display("%0t: overflow expected %0b got %0b", $time,
                           want.overflow, rsp_data.overflow);
                  fail_count++;
               end
            end
         end
         if (req_taken || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                     stall_cycles, sorted_results.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // request driver: bursts of back to back requests with random gaps
   always @(negedge clock) begin : driver
      req_type next_item;
      logic    next_valid;
      int      burst_left;
      int      send_gap;
      next_valid = req_valid;
      next_item  = req_data;
      if (!reset) begin
         if (req_valid && req_taken) next_valid = 1'b0;
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_reqs.size() > 0) begin
               next_item  = pending_reqs.pop_front();
               next_valid = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else if ($urandom_range(0, 4) == 0) begin
                  // long run with no idling
                  burst_left = $urandom_range(40, 70);
                  send_gap   = 0;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  send_gap   = $urandom_range(0, 7);
               end
            end
         end
      end
      req_valid <= next_valid;
      req_data  <= next_item;
   end

   // result receiver: stall patterns that change over time, plus long hold-offs on request
   always @(negedge clock) begin : receiver
      logic        r;
      int          hold_served;
      int          hold_left;
      int          mode_left;
      rx_mode_type rx_mode;
      if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         r = 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(10, 60);
         end else begin
            mode_left--;
         end
         case (rx_mode)
            RX_FREE:   r = 1'b1;
            RX_HALF:   r = $urandom_range(0, 1);
            RX_SPARSE: r = ($urandom_range(0, 3) == 0);
            default:   r = ($urandom_range(0, 3) != 0);
         endcase
      end
      rsp_ready <= r;
   end

   // mostly random values, with extremes and a narrow range for repeats
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0:       return 32'sh8000_0000;
               1:       return 32'sh7fff_ffff;
               2:       return 32'sd0;
               3:       return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         1, 2:    return $signed($urandom_range(0, 8)) - 32'sd4;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_req(input logic signed [DATA_W-1:0] v, input logic l);
      req_type r;
      r.value = v;
      r.last  = l;
      pending_reqs.push_back(r);
      queued_reqs++;
   endtask

   task automatic add_set(input int size);
      for (int i = 0; i < size; i++) push_req(pick_value(), i == size - 1);
   endtask

   // extremes, a single element and repeated values
   task automatic directed_sets();
      push_req(32'sh8000_0000, 1'b0);
      push_req(32'sh7fff_ffff, 1'b0);
      push_req(32'sd0, 1'b0);
      push_req(-32'sd1, 1'b0);
      push_req(32'sd1, 1'b0);
      push_req(32'sh5555_5555, 1'b0);
      push_req(32'shaaaa_aaaa, 1'b1);
      push_req(32'sd42, 1'b1);
      push_req(32'sd7, 1'b0);
      push_req(-32'sd7, 1'b0);
      push_req(32'sd7, 1'b0);
      push_req(32'sd7, 1'b1);
   endtask

   task automatic wait_idle();
      while (accepted_reqs != queued_reqs || sorted_results.size() != 0) @(negedge clock);
   endtask

   // order changes only once the block has drained
   task automatic set_order(input bit desc);
      wait_idle();
      repeat (IDLE_GAP) @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= desc;
      order_desc      = desc;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   initial begin
      int phase_start;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed sets in both orders
      set_order(1'b0);
      directed_sets();
      set_order(1'b1);
      directed_sets();

      // random sets; a full store, a last request that is dropped and a long overflow
      for (int p = 0; p < 6; p++) begin
         set_order(1'(p % 2));
         phase_start = queued_reqs;
         if (p == 1) begin
            // receiver holds off while the sender keeps going
            @(posedge clock);
            hold_asked++;
         end
         case (p)
            0:       add_set(MAX_ELEMS);
            1:       add_set(MAX_ELEMS + 6);
            2:       add_set(MAX_ELEMS + 1);
            default: ;
         endcase
         while (queued_reqs - phase_start < PHASE_REQS) begin
            if ($urandom_range(0, 19) == 0) add_set($urandom_range(MAX_ELEMS - 4, MAX_ELEMS + 4));
            else add_set($urandom_range(1, 8));
         end
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sorted_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, sorted_results.size());
         fail_count += sorted_results.size();
      end
      $display("covered %0d requests in %0d sets (%0d descending, %0d with dropped values)",
               accepted_reqs, sets_sorted, desc_sets, overflow_sets);
      $display("checked %0d sorted results, %0d errors", checked_results, fail_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
